### hw/rtl/pvb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pvb_pkg;

  localparam int SR_W      = 18;
  localparam int RATE_W    = 24;
  localparam int ATT_W     = 10;
  localparam int DEC_W     = 14;
  localparam int COUNT_W   = 5;
  localparam int DIV_NUM_W = 54;
  localparam int DIV_DEN_W = 32;

  localparam logic OP_TRIGGER = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
  localparam logic [23:0] ATTACK_MAX     = 24'hFF_FFFF;
  localparam logic [31:0] AMP_FLOOR      = 32'd4294967;
  localparam logic [31:0] SIN_C9         = 32'd172272;
  localparam logic [31:0] SIN_C7         = 32'd5026995;
  localparam logic [31:0] SIN_C5         = 32'd85569306;
  localparam logic [31:0] SIN_C3         = 32'd693598668;
  localparam logic [31:0] SIN_C1         = 32'd1686629713;

  // One voice entry as held in the state memory.
  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] phase_step;
    logic [23:0] attack;
    logic [23:0] attack_step;
    logic [31:0] amplitude;
    logic [31:0] decay;
  } voice_t;

  // Horner coefficients after the ninth-order term, highest order first.
  function automatic logic [31:0] horner_coef(input logic [1:0] k);
    logic [31:0] c;
    case (k)
      2'd0:    c = SIN_C7;
      2'd1:    c = SIN_C5;
      2'd2:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pvb_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module pvb_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [pvb_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [pvb_pkg::DIV_DEN_W-1:0]  den,
  output logic                                busy,
  output logic                                done,
  output logic [pvb_pkg::DIV_NUM_W-1:0]       quo
);
  import pvb_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = !diff[DIV_DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/polyphonic_sine_voice_bank.sv
// Polyphonic sine voice bank.
// Config: cfg_valid/cfg_ready/cfg_data writes sample_rate (Hz); always ready.
//   Write it only while the bank is idle.
// Input: in_valid/in_ready; op=0 triggers a voice (angular_rate, attack_ms,
//   decay_ms), op=1 ticks one mixed output sample.
// Output: out_valid/out_ready carries one result per input transaction:
//   sample_out, voice_taken, active_voices.
// One item is processed at a time. A trigger runs three passes of the shared
//   bit-serial divider. A tick runs every active voice through the single
//   shared 32x32 multiplier after a registered read of the voice memory.
// The next item is accepted while a finished result still waits in the output
//   register; a stalled receiver holds the bank only when the next result is
//   ready to be written.
// Reset clears all voices to inactive and sample_rate to 48000. Voice memory
//   entries are only read after a trigger has written them, so no clearing
//   pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_sine_voice_bank #(
  parameter int VOICE_COUNT      = 16,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pvb_pkg::SR_W-1:0]        cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            op,
  input  wire logic [pvb_pkg::RATE_W-1:0]      angular_rate,
  input  wire logic [pvb_pkg::ATT_W-1:0]       attack_ms,
  input  wire logic [pvb_pkg::DEC_W-1:0]       decay_ms,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]        sample_out,
  output logic                                 voice_taken,
  output logic [pvb_pkg::COUNT_W-1:0]          active_voices
);
  import pvb_pkg::*;

  localparam int VIDX_W    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int VCNT_W    = $clog2(VOICE_COUNT + 1);
  localparam int LOG_DEPTH = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - LOG_DEPTH)) - 32'd1);
  localparam logic [31:0] AMP_INIT   = 32'((64'd1 << 31) / VOICE_COUNT);
  localparam logic [DIV_NUM_W-1:0] ATT_NUM = DIV_NUM_W'(1000) << 22;
  localparam logic [DIV_NUM_W-1:0] DEC_NUM = DIV_NUM_W'(1000) << 32;
  localparam logic signed [34:0] LIM     = 35'sd2147483648;
  localparam logic [SAMPLE_BITS-1:0] SMP_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE, S_TMUL, S_DSTART, S_DWAIT, S_TWRITE,
    S_SCAN, S_LOAD, S_SQ, S_T2, S_HMUL, S_HSUB, S_SINMUL, S_CLAMP,
    S_AMUL, S_ATMUL, S_ACC, S_WB, S_DONE
  } state_t;

  state_t state;

  logic [SR_W-1:0]        sample_rate;
  logic [SR_W-1:0]        sr_eff;
  logic [VOICE_COUNT-1:0] active;

  // latched item
  logic                   op_r;
  logic [RATE_W-1:0]      rate_r;
  logic [ATT_W-1:0]       att_r;
  logic [DEC_W-1:0]       dec_r;

  // trigger path
  logic                   slot_found;
  logic [VIDX_W-1:0]      slot_idx;
  logic                   free_found;
  logic [VIDX_W-1:0]      free_idx;
  logic [27:0]            den_att;
  logic [31:0]            den_dec;
  logic [53:0]            num_p;
  logic [1:0]             div_sel;
  logic [31:0]            pstep;
  logic [23:0]            astep;
  logic [31:0]            fac_next;
  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [DIV_DEN_W-1:0]   div_den;
  logic [DIV_NUM_W-1:0]   div_quo;

  // tick path
  logic [VCNT_W-1:0]      vidx;
  voice_t                 cur;
  logic [31:0]            t;
  logic                   neg;
  logic [31:0]            t2;
  logic [31:0]            r;
  logic [1:0]             hk;
  logic [63:0]            prod;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic signed [34:0]     sum;
  logic signed [34:0]     sum_add;
  logic signed [34:0]     sum_next;
  logic [33:0]            r_wide;
  logic [31:0]            u_next;
  logic [31:0]            t_next;
  logic [24:0]            att_sum;
  logic [23:0]            att_next;
  logic [31:0]            amp_next;
  logic [34:0]            biased;
  logic [32:0]            shifted;
  logic [SAMPLE_BITS-1:0] smp_next;

  // voice memory
  voice_t                 mem [VOICE_COUNT];
  logic                   mem_we;
  logic [VIDX_W-1:0]      mem_waddr;
  voice_t                 mem_wdata;
  logic                   mem_re;
  voice_t                 mem_q;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign sr_eff    = (sample_rate == '0) ? SR_W'(1) : sample_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SR_W'(48000);
    end else if (cfg_valid && cfg_ready) begin
      sample_rate <= cfg_data;
    end
  end

  // lowest free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(i);
      end
    end
  end

  pvb_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign div_start = (state == S_DSTART);

  always_comb begin
    case (div_sel)
      2'd0: begin
        div_num = num_p;
        div_den = DIV_DEN_W'({sr_eff, 8'd0});
      end
      2'd1: begin
        div_num = ATT_NUM;
        div_den = DIV_DEN_W'(den_att);
      end
      default: begin
        div_num = DEC_NUM;
        div_den = den_dec;
      end
    endcase
  end

  always_comb begin
    if (|div_quo[DIV_NUM_W-1:32]) begin
      fac_next = '0;
    end else if (div_quo[31:0] == '0) begin
      fac_next = 32'hFFFF_FFFF;
    end else begin
      fac_next = 32'd0 - div_quo[31:0];
    end
  end

  // phase quantized to the table depth, folded into the first quadrant
  assign u_next = mem_q.phase & PHASE_MASK;
  assign t_next = u_next[30] ? (ONE_Q30 - {2'b00, u_next[29:0]})
                             : {2'b00, u_next[29:0]};

  // shared multiplier operands
  always_comb begin
    case (state)
      S_SQ:     begin mul_a = t;             mul_b = t;                  end
      S_HMUL:   begin mul_a = t2;            mul_b = r;                  end
      S_SINMUL: begin mul_a = t;             mul_b = r;                  end
      S_AMUL:   begin mul_a = r;             mul_b = cur.amplitude;      end
      S_ATMUL:  begin mul_a = prod[63:32];   mul_b = {8'd0, cur.attack}; end
      S_ACC:    begin mul_a = cur.amplitude; mul_b = cur.decay;          end
      default:  begin mul_a = '0;            mul_b = '0;                 end
    endcase
  end

  assign r_wide = prod[63:30];

  always_comb begin
    logic signed [34:0] mag_s;
    mag_s   = $signed({1'b0, prod[54:21]});
    sum_add = neg ? (sum - mag_s) : (sum + mag_s);
    if (sum_add > LIM) begin
      sum_next = LIM;
    end else if (sum_add < -LIM) begin
      sum_next = -LIM;
    end else begin
      sum_next = sum_add;
    end
  end

  assign att_sum  = {1'b0, cur.attack} + {1'b0, cur.attack_step};
  assign att_next = att_sum[24] ? ATTACK_MAX : att_sum[23:0];
  assign amp_next = (cur.attack[23:22] == 2'b00) ? cur.amplitude : prod[63:32];

  assign biased   = sum + LIM;
  assign shifted  = biased[32:0] >> (32 - SAMPLE_BITS);
  assign smp_next = shifted[SAMPLE_BITS] ? SMP_TOP
                  : {~shifted[SAMPLE_BITS-1], shifted[SAMPLE_BITS-2:0]};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata = cur;
    mem_re    = (state == S_SCAN) && (vidx != VCNT_W'(VOICE_COUNT))
                && active[vidx[VIDX_W-1:0]];
    case (state)
      S_TWRITE: begin
        mem_we    = 1'b1;
        mem_waddr = slot_idx;
        mem_wdata = '{phase: '0, phase_step: pstep, attack: '0,
                      attack_step: astep, amplitude: AMP_INIT, decay: fac_next};
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = vidx[VIDX_W-1:0];
        mem_wdata = cur;
        mem_wdata.phase = cur.phase + cur.phase_step;
        if (cur.attack[23:22] == 2'b00) begin
          mem_wdata.attack = att_next;
        end
        mem_wdata.amplitude = amp_next;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[vidx[VIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      out_valid <= 1'b0;
      div_sel   <= '0;
      vidx      <= '0;
      hk        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= op;
            rate_r     <= angular_rate;
            att_r      <= (attack_ms == '0) ? ATT_W'(1) : attack_ms;
            dec_r      <= (decay_ms == '0) ? DEC_W'(1) : decay_ms;
            slot_found <= free_found;
            slot_idx   <= free_idx;
            sum        <= '0;
            vidx       <= '0;
            div_sel    <= '0;
            if (op == OP_TICK) begin
              state <= S_SCAN;
            end else if (free_found) begin
              state <= S_TMUL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_TMUL: begin
          den_att <= sr_eff * att_r;
          den_dec <= sr_eff * dec_r;
          num_p   <= rate_r * INV_TWO_PI_Q32;
          state   <= S_DSTART;
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            case (div_sel)
              2'd0:    pstep <= div_quo[31:0];
              2'd1:    astep <= (|div_quo[DIV_NUM_W-1:24]) ? ATTACK_MAX : div_quo[23:0];
              default: ;
            endcase
            if (div_sel == 2'd2) begin
              state <= S_TWRITE;
            end else begin
              div_sel <= div_sel + 2'd1;
              state   <= S_DSTART;
            end
          end
        end
        S_TWRITE: begin
          active[slot_idx] <= 1'b1;
          state            <= S_DONE;
        end
        S_SCAN: begin
          if (vidx == VCNT_W'(VOICE_COUNT)) begin
            state <= S_DONE;
          end else if (mem_re) begin
            state <= S_LOAD;
          end else begin
            vidx <= vidx + 1'b1;
          end
        end
        S_LOAD: begin
          cur   <= mem_q;
          t     <= t_next;
          neg   <= u_next[31];
          state <= S_SQ;
        end
        S_SQ: begin
          prod  <= mul_a * mul_b;
          state <= S_T2;
        end
        S_T2: begin
          t2    <= prod[61:30];
          r     <= SIN_C9;
          hk    <= '0;
          state <= S_HMUL;
        end
        S_HMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_HSUB;
        end
        S_HSUB: begin
          r  <= horner_coef(hk) - prod[61:30];
          hk <= hk + 2'd1;
          state <= (hk == 2'd3) ? S_SINMUL : S_HMUL;
        end
        S_SINMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          r     <= (r_wide > 34'(ONE_Q30)) ? ONE_Q30 : r_wide[31:0];
          state <= S_AMUL;
        end
        S_AMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_ATMUL;
        end
        S_ATMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_ACC;
        end
        S_ACC: begin
          sum   <= sum_next;
          prod  <= mul_a * mul_b;
          state <= S_WB;
        end
        S_WB: begin
          if (amp_next < AMP_FLOOR) begin
            active[vidx[VIDX_W-1:0]] <= 1'b0;
          end
          vidx  <= vidx + 1'b1;
          state <= S_SCAN;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            sample_out    <= (op_r == OP_TICK) ? $signed(smp_next) : '0;
            voice_taken   <= (op_r == OP_TRIGGER) && slot_found;
            active_voices <= COUNT_W'($countones(active));
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("bank accepted an item while still working");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider running while bank idle");

  a_trigger_sample_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && voice_taken) |-> (sample_out == '0))
    else $error("trigger result carries a nonzero sample");

  a_no_mem_collision: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !mem_re)
    else $error("voice memory read and written in one cycle");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import pvb_pkg::*;

  localparam int NVOICE = 16;
  localparam int STALL_LIMIT  = 20000;

  typedef struct {
    logic              op;
    logic [RATE_W-1:0] rate;
    logic [ATT_W-1:0]  att;
    logic [DEC_W-1:0]  dec;
  } note_t;

  typedef struct {
    logic signed [15:0] smp;
    logic               taken;
    logic [COUNT_W-1:0] count;
  } mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_TICK;
  logic [RATE_W-1:0] angular_rate = '0;
  logic [ATT_W-1:0] attack_ms = '0;
  logic [DEC_W-1:0] decay_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] sample_out;
  logic voice_taken;
  logic [COUNT_W-1:0] active_voices;

  polyphonic_sine_voice_bank i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .angular_rate(angular_rate), .attack_ms(attack_ms), .decay_ms(decay_ms),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
    .voice_taken(voice_taken), .active_voices(active_voices)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [SR_W-1:0] rate_hz;
  bit          v_on [NVOICE];
  logic [31:0] v_phase [NVOICE];
  logic [31:0] v_step [NVOICE];
  logic [23:0] v_att [NVOICE];
  logic [23:0] v_att_step [NVOICE];
  logic [31:0] v_amp [NVOICE];
  logic [31:0] v_decay [NVOICE];

  note_t notes_q[$];
  mix_t  mix_q[$];
  int    n_taken = 0, n_checked = 0, n_errors = 0;
  int    n_trig = 0, n_tick = 0, n_cfg = 0, n_busy = 0, n_clip = 0;
  bit    in_taken = 0, cfg_taken = 0;
  int    burst_left = 0, gap_left = 0, quiet = 0, cyc = 0;

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < NVOICE; i++) if (v_on[i]) n++;
    return n;
  endfunction

  // Q30 sine magnitude of a cycle-fraction phase, 1024 steps per cycle
  function automatic longint unsigned sine_q30(input logic [31:0] ph, output bit neg);
    longint unsigned u, f, t, t2, r;
    u = longint'(ph[31:22]) << 22;
    f = u & 64'h3FFF_FFFF;
    t = u[30] ? 64'h4000_0000 - f : f;
    t2 = (t * t) >> 30;
    r = SIN_C9;
    r = SIN_C7 - ((t2 * r) >> 30);
    r = SIN_C5 - ((t2 * r) >> 30);
    r = SIN_C3 - ((t2 * r) >> 30);
    r = SIN_C1 - ((t2 * r) >> 30);
    r = (t * r) >> 30;
    if (r > 64'h4000_0000) r = 64'h4000_0000;
    neg = u[31];
    return r;
  endfunction

  function automatic mix_t predict_note(input note_t n);
    mix_t m;
    longint unsigned sr, att, dec, astep, q, fac, mag;
    longint sum, smp;
    int slot;
    bit neg;
    logic [24:0] a;
    sr = (rate_hz == 0) ? 1 : rate_hz;
    m = '{smp: 16'sd0, taken: 1'b0, count: '0};
    if (n.op == OP_TRIGGER) begin
      slot = -1;
      for (int i = NVOICE - 1; i >= 0; i--) if (!v_on[i]) slot = i;
      att = (n.att == 0) ? 1 : n.att;
      dec = (n.dec == 0) ? 1 : n.dec;
      if (slot >= 0) begin
        astep = (64'd1000 << 22) / (sr * att);
        q = (64'd1000 << 32) / (sr * dec);
        fac = (q >= (64'd1 << 32)) ? 0 : (64'd1 << 32) - q;
        if (fac > 64'hFFFF_FFFF) fac = 64'hFFFF_FFFF;
        if (astep > ATTACK_MAX) astep = ATTACK_MAX;
        v_phase[slot] = '0;
        v_step[slot] = 32'((longint'(n.rate) * INV_TWO_PI_Q32) / (256 * sr));
        v_att[slot] = '0;
        v_att_step[slot] = astep[23:0];
        v_amp[slot] = 32'h8000_0000 / NVOICE;
        v_decay[slot] = fac[31:0];
        v_on[slot] = 1;
        m.taken = 1'b1;
      end else begin
        n_busy++;
      end
      n_trig++;
    end else begin
      sum = 0;
      for (int i = 0; i < NVOICE; i++) begin
        if (!v_on[i]) continue;
        mag = sine_q30(v_phase[i], neg);
        mag = (mag * v_amp[i]) >> 32;
        mag = (mag * v_att[i]) >> 21;
        sum += neg ? -longint'(mag) : longint'(mag);
        if (sum > 64'sh8000_0000) begin
          sum = 64'sh8000_0000;
          n_clip++;
        end else if (sum < -64'sh8000_0000) begin
          sum = -64'sh8000_0000;
          n_clip++;
        end
        if (v_att[i] < 24'h40_0000) begin
          a = v_att[i] + v_att_step[i];
          v_att[i] = (a > ATTACK_MAX) ? ATTACK_MAX : a[23:0];
        end else begin
          v_amp[i] = 32'((64'(v_amp[i]) * v_decay[i]) >> 32);
        end
        v_phase[i] = v_phase[i] + v_step[i];
        if (v_amp[i] < AMP_FLOOR) v_on[i] = 0;
      end
      // the biased sum is never negative
      smp = ((sum + 64'sh8000_0000) >>> 16) - 32768;
      if (smp > 32767) smp = 32767;
      m.smp = smp[15:0];
      n_tick++;
    end
    m.count = COUNT_W'(live_count());
    return m;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk) begin
    mix_t w;
    if (!rst) begin
      in_taken <= in_valid && in_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        rate_hz = cfg_data;
        n_cfg++;
      end
      if (in_valid && in_ready) begin
        mix_q.push_back(predict_note('{op, angular_rate, attack_ms, decay_ms}));
        n_taken <= n_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (mix_q.size() == 0) begin
          $display("unexpected result transaction");
          n_errors++;
        end else begin
          w = mix_q.pop_front();
          if (sample_out !== w.smp) report("sample_out", sample_out, w.smp);
          if (voice_taken !== w.taken) report("voice_taken", voice_taken, w.taken);
          if (active_voices !== w.count) report("active_voices", active_voices, w.count);
        end
        n_checked <= n_checked + 1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // sender: bursts with random gaps
  always @(negedge clk) begin
    note_t n;
    logic nv;
    nv = in_valid;
    if (!rst && (!in_valid || in_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (notes_q.size() > 0) begin
        n = notes_q.pop_front();
        op <= n.op;
        angular_rate <= n.rate;
        attack_ms <= n.att;
        decay_ms <= n.dec;
        nv = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid <= nv;
  end

  // receiver: stall pattern rotates among four patterns
  always @(negedge clk) begin
    cyc++;
    case ((cyc / 700) % 4)
      0: begin out_ready <= 1'b1; end
      1: begin out_ready <= ($urandom_range(0, 3) == 0); end
      2: begin out_ready <= ($urandom_range(0, 1) == 1); end
      default: begin out_ready <= (cyc % 16) < 12; end
    endcase
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (!(notes_q.size() == 0 && !in_valid && n_taken == n_checked));
  endtask

  task automatic write_rate(input logic [SR_W-1:0] v);
    wait_idle();
    repeat (300) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  function automatic note_t make_tick();
    return '{OP_TICK, RATE_W'($urandom), ATT_W'($urandom), DEC_W'($urandom)};
  endfunction

  // triggers scaled so voices live a few hundred ticks at this rate;
  // with full set, every field is drawn over its full width
  function automatic note_t make_trigger(input bit full);
    note_t n;
    int sr;
    sr = (rate_hz == 0) ? 1 : rate_hz;
    n.op = OP_TRIGGER;
    n.rate = RATE_W'($urandom);
    if (full) begin
      n.att = ATT_W'($urandom);
      n.dec = DEC_W'($urandom);
    end else begin
      n.att = ATT_W'($urandom_range(1, (50000 / sr + 1 > 1023) ? 1023 : 50000 / sr + 1));
      n.dec = DEC_W'($urandom_range(1, 40000 / sr + 1));
    end
    return n;
  endfunction

  // with pause set, the sender drains and every result comes back mid-phase
  task automatic random_phase(input int count, input bit full, input bit pause);
    for (int k = 0; k < count; k++) begin
      if (pause && k == count / 2) begin
        wait_idle();
      end
      if ($urandom_range(0, 9) < 3) notes_q.push_back(make_trigger(full));
      else notes_q.push_back(make_tick());
    end
  endtask

  initial begin
    logic [SR_W-1:0] rates [4];
    rates = '{18'd8000, 18'd192000, 18'h3FFFF, 18'd48000};
    rate_hz = 18'd48000;
    for (int i = 0; i < NVOICE; i++) v_on[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // a few items at the reset rate
    notes_q.push_back('{OP_TRIGGER, 24'h1234, 10'd1, 14'd1});
    notes_q.push_back('{OP_TICK, 24'h0, 10'd0, 14'd0});
    notes_q.push_back('{OP_TRIGGER, 24'h80_0000, 10'd2, 14'd1});
    notes_q.push_back('{OP_TICK, 24'hFF_FFFF, 10'h3FF, 14'h3FFF});
    // rate zero: everything dies fast, so the directed extremes cannot clog the bank
    write_rate(18'd0);
    notes_q.push_back('{OP_TRIGGER, 24'h0, 10'd0, 14'd0});
    notes_q.push_back('{OP_TRIGGER, 24'hFF_FFFF, 10'd1023, 14'd16383});
    notes_q.push_back('{OP_TRIGGER, 24'h00_0001, 10'd1000, 14'd10000});
    notes_q.push_back('{OP_TRIGGER, 24'hAA_AAAA, 10'd1, 14'd1});
    for (int i = 0; i < 13; i++)
      notes_q.push_back('{OP_TRIGGER, RATE_W'($urandom), 10'd1, DEC_W'(16383 - i)});
    notes_q.push_back('{OP_TICK, 24'h0, 10'd0, 14'd0});
    for (int i = 0; i < 5; i++) notes_q.push_back(make_tick());
    wait_idle();
    random_phase(300, 1, 0);
    foreach (rates[r]) begin
      write_rate(rates[r]);
      random_phase(260, 0, r == 1);
    end
    wait_idle();
    repeat (300) @(posedge clk);
    if (mix_q.size() != 0) begin
      $display("%0d expected results never arrived", mix_q.size());
      n_errors++;
    end
    $display("covered %0d triggers (%0d with the bank full) and %0d ticks, %0d clipped sums",
             n_trig, n_busy, n_tick, n_clip);
    $display("over %0d sample rate writes; %0d results checked, %0d mismatches",
             n_cfg, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
